>>> design/pid_trapezoid_integral_reset_macros.svh
// ----------------------------------------------------------------------------
// pid_trapezoid_integral_reset_macros
// assertion shorthands shared by the pid controller files
// ----------------------------------------------------------------------------
`ifndef PID_TRAPEZOID_INTEGRAL_RESET_MACROS_SVH
`define PID_TRAPEZOID_INTEGRAL_RESET_MACROS_SVH

// same-cycle implication, disabled during reset
`define PIDTI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PIDTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pidti_pkg.sv
// ----------------------------------------------------------------------------
// pidti_pkg
// types and constants of the trapezoidal-integral pid controller
// ----------------------------------------------------------------------------
package pidti_pkg;

  // configuration register map
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgSetpoint = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgGainP    = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgGainI    = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgGainD    = 8'd3;

  // field widths
  localparam int SampleW = 16;
  localparam int GainW   = 16;
  localparam int ErrW    = 17;
  localparam int DiffW   = 18;
  localparam int IntegW  = 19;
  localparam int DriveW  = 40;

  // product widths
  localparam int PropW  = GainW + ErrW;
  localparam int DerivW = GainW + DiffW;
  localparam int IprodW = GainW + IntegW;

  // doubled integral limit (magnitude 50 in q12.4, times two)
  localparam logic signed [IntegW-1:0] IntegLimit = 19'sd1600;

  // error stage result
  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [DiffW-1:0]  diff;
    logic signed [IntegW-1:0] integ;
  } pidti_err_t;

endpackage

>>> design/pidti_channels_if.sv
// ----------------------------------------------------------------------------
// pidti channels
// valid/ready channels for samples, controller output and register writes
// ----------------------------------------------------------------------------

// measured sample channel
interface pidti_sample_if import pidti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] measured_value;

  modport source (output valid, output measured_value, input ready);
  modport sink (input valid, input measured_value, output ready);
endinterface

// controller output channel
interface pidti_drive_if import pidti_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive_adjust;

  modport source (output valid, output drive_adjust, input ready);
  modport sink (input valid, input drive_adjust, output ready);
endinterface

// register write channel
interface pidti_cfg_if import pidti_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [GainW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/pid_trapezoid_integral_reset.sv
// ----------------------------------------------------------------------------
// pid_trapezoid_integral_reset
// pid controller with a trapezoidal integral that clears itself once large.
// Takes one q12.4 sample per cycle while the output is not stalled and returns
// one q.12 drive value per sample, in order. The first stage forms the error
// and updates the doubled integral and last error in the same cycle, so a
// sample can follow in every cycle unless a stall holds it up; the second stage
// holds the three gain products, the third the summed output. A stalled output
// only holds up the input once all three stages are full. Registers are to be
// written only while the controller holds no samples; the block does not
// enforce this. The write channel is always ready.
// ----------------------------------------------------------------------------
`include "pid_trapezoid_integral_reset_macros.svh"

module pid_trapezoid_integral_reset import pidti_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  pidti_sample_if.sink  sample,
  pidti_drive_if.source drive,
  pidti_cfg_if.sink     cfg
);

  logic signed [GainW-1:0] setpoint;
  logic signed [GainW-1:0] gain_p;
  logic signed [GainW-1:0] gain_i;
  logic signed [GainW-1:0] gain_d;

  logic       load;
  logic       rdy1;
  logic       rdy2;
  logic       rdy3;
  logic       v1;
  logic       v2;
  pidti_err_t s1;

  logic signed [PropW-1:0]  prop;
  logic signed [DerivW-1:0] deriv;
  logic signed [IprodW-1:0] iprod;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
      gain_p   <= '0;
      gain_i   <= '0;
      gain_d   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CfgSetpoint: setpoint <= cfg.data;
        CfgGainP:    gain_p   <= cfg.data;
        CfgGainI:    gain_i   <= cfg.data;
        CfgGainD:    gain_d   <= cfg.data;
        default: ;
      endcase
    end
  end

  // per-stage flow control
  assign rdy3 = !drive.valid || drive.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign sample.ready = rdy1;
  assign load = sample.valid && rdy1;

  // error and integral stage
  pidti_err_stage u_err (
    .clk            (clk),
    .rst            (rst),
    .setpoint       (setpoint),
    .measured_value (sample.measured_value),
    .load           (load),
    .take           (rdy2),
    .stage_valid    (v1),
    .stage          (s1)
  );

  // gain products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      prop  <= PropW'(gain_p) * PropW'(s1.err);
      deriv <= DerivW'(gain_d) * DerivW'(s1.diff);
      iprod <= IprodW'(gain_i) * IprodW'(s1.integ);
    end
  end

  // output sum, integral term floored to 12 fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      drive.valid <= 1'b0;
    end else if (rdy3) begin
      drive.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      drive.drive_adjust <= DriveW'(prop) + DriveW'(deriv) + DriveW'(iprod >>> 1);
    end
  end

  `PIDTI_ASSERT_SAME(a_out_source, clk, rst, $rose(drive.valid), $past(v2), "output valid without a product stage")
  `PIDTI_ASSERT_NEXT(a_prod_hold, clk, rst, v2 && !rdy3, v2 && $stable(prop) && $stable(iprod), "product stage lost while stalled")
  `PIDTI_ASSERT_SAME(a_no_drop, clk, rst, load && v1, rdy2, "error stage overwritten while full")

endmodule

>>> design/pidti_err_stage.sv
// ----------------------------------------------------------------------------
// pidti_err_stage
// error, error difference and trapezoidal integral update with its state
// ----------------------------------------------------------------------------
`include "pid_trapezoid_integral_reset_macros.svh"

module pidti_err_stage import pidti_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [GainW-1:0]   setpoint,
  input  logic signed [SampleW-1:0] measured_value,
  input  logic                      load,
  input  logic                      take,
  output logic                      stage_valid,
  output pidti_err_t                stage
);

  logic signed [ErrW-1:0]   last_error;
  logic signed [IntegW-1:0] integral;

  logic signed [ErrW-1:0]   err;
  logic signed [DiffW-1:0]  diff;
  logic                     below_limit;
  logic signed [IntegW-1:0] integral_next;

  // error and its change since the last sample
  assign err  = ErrW'(setpoint) - ErrW'(measured_value);
  assign diff = DiffW'(err) - DiffW'(last_error);

  // integral grows while small, otherwise it is cleared
  assign below_limit = (integral < IntegLimit) && (integral > -IntegLimit);
  assign integral_next = below_limit ?
                         (integral + IntegW'(err) + IntegW'(last_error)) : '0;

  // controller state, advanced on every accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integral   <= '0;
    end else if (load) begin
      last_error <= err;
      integral   <= integral_next;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.err   <= err;
      stage.diff  <= diff;
      stage.integ <= integral_next;
    end
  end

  `PIDTI_ASSERT_NEXT(a_integ_clear, clk, rst, load && !below_limit, integral == '0, "integral not cleared past limit")
  `PIDTI_ASSERT_NEXT(a_state_hold, clk, rst, !load, $stable(integral) && $stable(last_error), "state moved without a sample")
  `PIDTI_ASSERT_NEXT(a_stage_fill, clk, rst, load, stage_valid && stage.integ == integral, "stage and integral disagree")

endmodule

>>> test/tb_pid_trapezoid_integral_reset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_trapezoid_integral_reset
// Self-checking bench for the trapezoidal-integral pid controller. A short
// table of directed rows covers reset, field extremes, an ignored register
// index and both sides of the integral clearing limit. Random phases with
// fresh gains and setpoints follow. Every drive value is compared with a local
// model of the controller, or with the table value for rows marked as typed.
// Both handshakes idle and stall at random.
module tb_pid_trapezoid_integral_reset;
  import pidti_pkg::*;

  // an index outside the register map, with low bits that alias setpoint
  localparam logic [CfgIdxW-1:0] CfgUnused = 8'd200;
  localparam int DirectedRows = 28;
  localparam int RandomPhases = 8;
  localparam int PhaseSamples = 100;
  localparam int MaxGap = 13;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_AIM} row_kind_t;

  // value is write data, a sample, or the integral to land on for aimed rows
  typedef struct {
    row_kind_t          kind;
    logic [CfgIdxW-1:0] index;
    int                 value;
    bit                 typed;
    longint             drive;
  } stim_row_t;

  stim_row_t directed_rows [DirectedRows] = '{
    // gains are zero after reset, so every output is zero
    '{ROW_SAMPLE, '0, 0, 1'b1, 0},
    '{ROW_SAMPLE, '0, -32768, 1'b1, 0},
    '{ROW_SAMPLE, '0, 32767, 1'b1, 0},
    // proportional only: error 1.0 at gain 1.0, the unused index changes nothing
    '{ROW_WRITE, CfgSetpoint, 16, 1'b0, 0},
    '{ROW_WRITE, CfgGainP, 256, 1'b0, 0},
    '{ROW_WRITE, CfgUnused, 32767, 1'b0, 0},
    '{ROW_SAMPLE, '0, 0, 1'b1, 4096},
    '{ROW_SAMPLE, '0, 0, 1'b1, 4096},
    // largest errors and gains
    '{ROW_WRITE, CfgSetpoint, 32767, 1'b0, 0},
    '{ROW_WRITE, CfgGainP, -32768, 1'b0, 0},
    '{ROW_WRITE, CfgGainD, 32767, 1'b0, 0},
    '{ROW_WRITE, CfgGainI, 32767, 1'b0, 0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, 0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, 0},
    '{ROW_WRITE, CfgSetpoint, -32768, 1'b0, 0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, 0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, 0},
    // settle the integral below the limit, then walk it onto the limit
    '{ROW_WRITE, CfgSetpoint, 0, 1'b0, 0},
    '{ROW_WRITE, CfgGainI, 255, 1'b0, 0},
    '{ROW_SAMPLE, '0, 0, 1'b0, 0},
    '{ROW_SAMPLE, '0, 0, 1'b0, 0},
    '{ROW_AIM, '0, 1599, 1'b0, 0},
    '{ROW_AIM, '0, 1600, 1'b0, 0},
    '{ROW_SAMPLE, '0, 0, 1'b0, 0},
    '{ROW_AIM, '0, -1600, 1'b0, 0},
    '{ROW_SAMPLE, '0, 0, 1'b0, 0},
    '{ROW_AIM, '0, -1599, 1'b0, 0},
    '{ROW_SAMPLE, '0, 0, 1'b0, 0}
  };

  logic clk = 1'b0;
  logic rst;

  pidti_sample_if sample_ch ();
  pidti_drive_if  drive_ch ();
  pidti_cfg_if    cfg_ch ();

  pid_trapezoid_integral_reset u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .drive  (drive_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  // controller model state and register copies
  logic signed [GainW-1:0]  setpoint_reg;
  logic signed [GainW-1:0]  kp_reg;
  logic signed [GainW-1:0]  ki_reg;
  logic signed [GainW-1:0]  kd_reg;
  logic signed [ErrW-1:0]   err_prev;
  logic signed [IntegW-1:0] integ_twice;

  logic signed [DriveW-1:0] drive_expected [$];
  int fail_count = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  // one controller step: error, doubled trapezoid integral with clearing, output
  function automatic logic signed [DriveW-1:0] step_controller(
    input logic signed [SampleW-1:0] meas
  );
    longint err;
    longint mag;
    longint iprod;
    longint total;
    err = longint'(setpoint_reg) - longint'(meas);
    mag = (integ_twice < 0) ? -longint'(integ_twice) : longint'(integ_twice);
    total = longint'(kp_reg) * err + longint'(kd_reg) * (err - longint'(err_prev));
    if (mag < longint'(IntegLimit)) begin
      integ_twice = IntegW'(longint'(integ_twice) + err + longint'(err_prev));
    end else begin
      integ_twice = '0;
    end
    // integral product carries one extra fraction bit, dropped with floor
    iprod = longint'(ki_reg) * longint'(integ_twice);
    total = total + (iprod >>> 1);
    err_prev = ErrW'(err);
    return DriveW'(total);
  endfunction

  function automatic int src_gap();
    return src_steady ? 0 : int'($urandom_range(0, MaxGap));
  endfunction

  function automatic int sink_stall();
    return sink_steady ? 0 : int'($urandom_range(0, MaxGap));
  endfunction

  // register values for a random phase: first phase all high, second all low
  function automatic logic [GainW-1:0] reg_value(input int phase);
    if (phase == 0) return 16'h7fff;
    if (phase == 1) return 16'h8000;
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3, 4, 5: return GainW'(int'($urandom_range(0, 1024)) - 512);
      default: return GainW'($urandom);
    endcase
  endfunction

  // mostly small errors so the integral climbs and clears, plus wide noise
  function automatic logic signed [SampleW-1:0] next_measurement();
    int pick;
    int err;
    pick = $urandom_range(0, 9);
    err = int'($urandom_range(0, 400)) - 200;
    if (pick <= 6) return SampleW'(int'(setpoint_reg) - err);
    if (pick == 7) return SampleW'($urandom);
    if (pick == 8) begin
      case ($urandom_range(0, 1))
        0: return 16'sh8000;
        default: return 16'sh7fff;
      endcase
    end
    return setpoint_reg;
  endfunction

  // sample transaction; the model runs when the sample is taken
  task automatic send_sample(
    input logic signed [SampleW-1:0] meas,
    input bit                        typed,
    input logic signed [DriveW-1:0]  typed_drive
  );
    int gap;
    logic signed [DriveW-1:0] model;
    gap = src_gap();
    if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.measured_value <= meas;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    model = step_controller(meas);
    drive_expected.push_back(typed ? typed_drive : model);
  endtask

  // register write transaction, only once the controller has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] wdata);
    if (sample_ch.valid) sample_ch.valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= wdata;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      CfgSetpoint: setpoint_reg = wdata;
      CfgGainP:    kp_reg = wdata;
      CfgGainI:    ki_reg = wdata;
      CfgGainD:    kd_reg = wdata;
      default: ;
    endcase
  endtask

  // output side: random stall before each transaction
  initial begin
    int stall;
    drive_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_stall();
      if (stall > 0) begin
        drive_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      drive_ch.ready <= 1'b1;
      do @(posedge clk); while (!(drive_ch.valid && drive_ch.ready));
    end
  end

  // compare each drive value with the oldest prediction
  always @(posedge clk) begin
    logic signed [DriveW-1:0] want;
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      if (drive_expected.size() == 0) begin
        $error("drive_adjust: expected none, got %0d", drive_ch.drive_adjust);
        fail_count++;
      end else begin
        want = drive_expected.pop_front();
        if (drive_ch.drive_adjust !== want) begin
          $error("drive_adjust: expected %0d, got %0d", want, drive_ch.drive_adjust);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int row;
    int phase;
    int n;
    logic signed [SampleW-1:0] aim_meas;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.measured_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    setpoint_reg = '0;
    kp_reg = '0;
    ki_reg = '0;
    kd_reg = '0;
    err_prev = '0;
    integ_twice = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (row = 0; row < DirectedRows; row++) begin
      case (directed_rows[row].kind)
        ROW_WRITE: write_reg(directed_rows[row].index, GainW'(directed_rows[row].value));
        ROW_SAMPLE: send_sample(SampleW'(directed_rows[row].value), directed_rows[row].typed,
                                DriveW'(directed_rows[row].drive));
        default: begin
          // pick the error that lands the doubled integral on the target
          aim_meas = SampleW'(int'(setpoint_reg) -
                              (directed_rows[row].value - int'(integ_twice) - int'(err_prev)));
          send_sample(aim_meas, 1'b0, '0);
        end
      endcase
    end

    // random phases, each with its own registers and idling mix
    for (phase = 0; phase < RandomPhases; phase++) begin
      src_steady = (phase == 2) || ($urandom_range(0, 4) == 0);
      sink_steady = (phase == 5) || ($urandom_range(0, 4) == 0);
      write_reg(CfgSetpoint, reg_value(phase));
      write_reg(CfgGainP, reg_value(phase));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CfgIdxW'($urandom_range(4, 255)), GainW'($urandom));
      end
      write_reg(CfgGainI, reg_value(phase));
      write_reg(CfgGainD, reg_value(phase));
      for (n = 0; n < PhaseSamples; n++) begin
        send_sample(next_measurement(), 1'b0, '0);
      end
    end

    // drain and let any stray output show up
    sample_ch.valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && drive_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
